// ----- hdl/flux_table_bilinear_interp_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef FLUX_TABLE_BILINEAR_INTERP_ASSERT_SVH
`define FLUX_TABLE_BILINEAR_INTERP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FTBI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ftbi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FTBI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ftbi assertion failed");

`endif

// ----- hdl/ftbi_pkg.sv -----
`timescale 1ns / 1ps

package ftbi_pkg;

	localparam int ZENITH_BINS   = 20;
	localparam int AZIMUTH_BINS  = 12;
	localparam int ENERGY_POINTS = 101;
	localparam int FLAVORS       = 4;
	localparam int CELL_COUNT    = ZENITH_BINS * AZIMUTH_BINS * ENERGY_POINTS;

	localparam int GA_W  = $clog2(CELL_COUNT);
	localparam int FA_W  = $clog2(FLAVORS * CELL_COUNT);
	localparam int ROW_W = $clog2(ZENITH_BINS * AZIMUTH_BINS);
	localparam int EB_W  = $clog2(ENERGY_POINTS);
	localparam int ZB_W  = $clog2(ZENITH_BINS);

	localparam int ENERGY_W = 48;
	localparam int FLUX_W   = 64;
	localparam int WEIGHT_W = 33;
	localparam int COS_W    = 21;
	localparam int ACC_W    = 97;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_GRID    = 3'd0,
		SEL_NUMU    = 3'd1,
		SEL_NUMUBAR = 3'd2,
		SEL_NUE     = 3'd3,
		SEL_NUEBAR  = 3'd4
	} sel_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ERR_ENERGY = 2'd1,
		ST_ERR_COS    = 2'd2
	} status_t;

	typedef logic signed [COS_W-1:0] cos_tab_t [ZENITH_BINS];

	// Row i of the cosine grid: (0.95 - 0.10*i) in Q1.16, rounded to nearest.
	function automatic cos_tab_t build_cos_grid();
		int       n;
		cos_tab_t t;
		for (int i = 0; i < ZENITH_BINS; i++) begin
			n = (19 - 2 * i) * 65536;
			if (n >= 0) begin
				t[i] = COS_W'((n + 10) / 20);
			end else begin
				t[i] = COS_W'(-((-n + 10) / 20));
			end
		end
		return t;
	endfunction

	localparam cos_tab_t COS_GRID = build_cos_grid();

	typedef struct packed {
		logic              grid_we;
		logic              flux_we;
		logic [GA_W-1:0]   grid_addr;
		logic [FA_W-1:0]   flux_addr;
		logic [FLUX_W-1:0] data;
	} store_wr_t;

endpackage

// ----- hdl/ftbi_store.sv -----
`timescale 1ns / 1ps

module ftbi_store import ftbi_pkg::*; (
	input  logic                clk,
	input  store_wr_t           wr,
	input  logic [GA_W-1:0]     grid_raddr,
	input  logic [FA_W-1:0]     flux_raddr,
	output logic [ENERGY_W-1:0] grid_rdata,
	output logic [FLUX_W-1:0]   flux_rdata
);

	logic [ENERGY_W-1:0] grid_mem [CELL_COUNT];
	logic [FLUX_W-1:0]   flux_mem [FLAVORS*CELL_COUNT];
	logic [ENERGY_W-1:0] grid_rdata_q;
	logic [FLUX_W-1:0]   flux_rdata_q;

	always_ff @(posedge clk) begin
		if (wr.grid_we) begin
			grid_mem[wr.grid_addr] <= wr.data[ENERGY_W-1:0];
		end
		grid_rdata_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.flux_we) begin
			flux_mem[wr.flux_addr] <= wr.data;
		end
		flux_rdata_q <= flux_mem[flux_raddr];
	end

	assign grid_rdata = grid_rdata_q;
	assign flux_rdata = flux_rdata_q;

endmodule

// ----- hdl/ftbi_frac.sv -----
`timescale 1ns / 1ps

module ftbi_frac import ftbi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ENERGY_W-1:0] num,
	input  logic [ENERGY_W-1:0] den,
	output logic                done,
	output logic [WEIGHT_W-1:0] w
);

	logic                busy_q;
	logic                done_q;
	logic [4:0]          cnt_q;
	logic [ENERGY_W:0]   r_q;
	logic [31:0]         q_q;
	logic [ENERGY_W-1:0] den_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [ENERGY_W:0]   r_sh;
	logic                bit_n;
	logic [ENERGY_W:0]   r_n;

	// One restoring step per cycle.
	always_comb begin
		r_sh  = {r_q[ENERGY_W-1:0], 1'b0};
		bit_n = (r_sh >= {1'b0, den_q});
		r_n   = bit_n ? (r_sh - {1'b0, den_q}) : r_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q <= den;
				if (den == '0) begin
					w_q    <= '0;
					done_q <= 1'b1;
				end else if (num >= den) begin
					w_q    <= {1'b1, 32'd0};
					done_q <= 1'b1;
				end else begin
					r_q    <= {1'b0, num};
					q_q    <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				r_q   <= r_n;
				q_q   <= {q_q[30:0], bit_n};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					w_q    <= {1'b0, q_q[30:0], bit_n};
				end
			end
		end
	end

	assign done = done_q;
	assign w    = w_q;

endmodule

// ----- hdl/ftbi_blend.sv -----
`timescale 1ns / 1ps

module ftbi_blend import ftbi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [FLUX_W-1:0]   a,
	input  logic [FLUX_W-1:0]   b,
	input  logic [WEIGHT_W-1:0] w,
	output logic                done,
	output logic [FLUX_W-1:0]   result
);

	logic                busy_q;
	logic                done_q;
	logic [2:0]          cnt_q;
	logic [FLUX_W-1:0]   a_q;
	logic [FLUX_W-1:0]   b_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [WEIGHT_W-1:0] wc_q;
	logic [64:0]         prod_s1;
	logic [ACC_W-1:0]    acc_q;
	logic [31:0]         mul_x;
	logic [WEIGHT_W-1:0] mul_w;
	logic [ACC_W-1:0]    addend;

	// Four 32x33 partial products: a lo/hi by w, then b lo/hi by 1-w.
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mul_x = a_q[31:0];
			2'd1:    mul_x = a_q[63:32];
			2'd2:    mul_x = b_q[31:0];
			default: mul_x = b_q[63:32];
		endcase
		mul_w  = cnt_q[1] ? wc_q : w_q;
		// Product of the previous step: odd steps are the high halves.
		addend = cnt_q[0] ? ACC_W'(prod_s1) : {prod_s1, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				w_q    <= w;
				wc_q   <= {1'b1, 32'd0} - w;
				acc_q  <= ACC_W'(32'h8000_0000);
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					prod_s1 <= mul_x * mul_w;
				end
				if (cnt_q != 3'd0) begin
					acc_q <= acc_q + addend;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q[ACC_W-1] ? '1 : acc_q[95:32];

endmodule

// ----- hdl/flux_table_bilinear_interp.sv -----
// Bilinear flux table interpolator. A load beat (command 0) writes one energy grid word or one
// flavor flux word of the zenith x azimuth x energy table; out-of-range loads are dropped and
// produce no result. A query beat (command 1) returns one result beat: the flux interpolated
// in energy and then in cosine of zenith, or zero with a nonzero status when the energy falls
// outside the chosen interval of the used cell. Tables are undefined until written; a query
// must only touch written entries. The block works on one beat at a time and drops in_ready
// while busy. A load holds in_ready low through its row, cell and write states. A query holds
// in_ready low while it runs and while its result waits for the output register. The energy
// bin search, run only when the energy lies inside the grid of cell (0,0), walks that grid
// point by point through the single grid read port; the two weights are found one after the
// other in the shared bit-serial divider, which skips its bit steps when the denominator is
// zero or the fraction is at least 1; and the three blends run one after the other in the
// shared 32x33 multiply-accumulate unit. A finished result waits in the output register.
`timescale 1ns / 1ps

module flux_table_bilinear_interp import ftbi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [4:0]          zenith_index,
	input  logic [3:0]          azimuth_index,
	input  logic [6:0]          energy_index,
	input  logic [2:0]          table_select,
	input  logic [63:0]         table_value,
	input  logic [47:0]         query_energy,
	input  logic signed [17:0]  query_cos_zenith,
	input  logic [3:0]          query_azimuth,
	input  logic [1:0]          query_flavor,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         flux_value,
	output logic [1:0]          status
);

	typedef enum logic [4:0] {
		S_IDLE, S_ROW, S_CELL, S_LDWR,
		S_G0, S_GL, S_GCHK, S_SRD, S_SCMP, S_COS,
		S_C0, S_C1, S_C2, S_C3, S_C4, S_CHK, S_DIVE, S_DIVC,
		S_F0, S_F1, S_F2, S_B0, S_F3, S_F4, S_F5, S_B1, S_B2, S_DONE
	} state_t;

	localparam logic [FA_W-1:0] ROWSTEP = FA_W'(AZIMUTH_BINS * ENERGY_POINTS);
	localparam logic signed [COS_W-1:0] COS_HI = COS_GRID[0];
	localparam logic signed [COS_W-1:0] COS_LO = COS_GRID[ZENITH_BINS-1];

	state_t                     state_q;
	cmd_t                       cmd_q;
	logic [4:0]                 z_q;
	logic [3:0]                 az_q;
	logic [6:0]                 e_q;
	logic [2:0]                 sel_q;
	logic [FLUX_W-1:0]          val_q;
	logic [ENERGY_W-1:0]        en_q;
	logic signed [17:0]         cz_q;
	logic [1:0]                 flav_q;
	logic [ENERGY_W-1:0]        g00_q;
	logic [ENERGY_W-1:0]        prev_q;
	logic [EB_W-1:0]            idx_q;
	logic [EB_W-1:0]            eb_q;
	logic signed [COS_W-1:0]    czc_q;
	logic [ZB_W-1:0]            zb_q;
	logic signed [COS_W-1:0]    cb1_q;
	logic signed [COS_W-1:0]    cb2_q;
	logic [ROW_W-1:0]           row_q;
	logic [GA_W-1:0]            cell_q;
	logic [FA_W-1:0]            fbase_q;
	logic [ENERGY_W-1:0]        gc0_q;
	logic [ENERGY_W-1:0]        ec_q;
	logic [ENERGY_W:0]          eb1_q;
	logic [ENERGY_W:0]          eb2_q;
	logic [WEIGHT_W-1:0]        w_e_q;
	logic [WEIGHT_W-1:0]        w_c_q;
	logic [FLUX_W-1:0]          fa_q;
	logic [FLUX_W-1:0]          r0_q;
	logic [FLUX_W-1:0]          res_flux_q;
	status_t                    res_status_q;
	logic [FLUX_W-1:0]          flux_q;
	status_t                    status_q;
	logic                       out_valid_q;

	store_wr_t                  wr;
	logic [GA_W-1:0]            grid_raddr;
	logic [FA_W-1:0]            flux_raddr;
	logic [ENERGY_W-1:0]        grid_rdata;
	logic [FLUX_W-1:0]          flux_rdata;
	logic                       load_ok;
	logic [3:0]                 az_sat;
	logic signed [COS_W-1:0]    cz_ext;
	logic signed [COS_W-1:0]    czc_n;
	logic [ZB_W-1:0]            zb_n;
	logic [ENERGY_W-1:0]        ec_lo;
	logic [ENERGY_W-1:0]        ec_n;
	logic                       chk_ok;
	logic [ENERGY_W:0]          e_den;
	logic signed [COS_W-1:0]    c_den;
	logic                       div_start;
	logic [ENERGY_W-1:0]        div_num;
	logic [ENERGY_W-1:0]        div_den;
	logic                       div_done;
	logic [WEIGHT_W-1:0]        div_w;
	logic                       bl_start;
	logic [FLUX_W-1:0]          bl_a;
	logic [FLUX_W-1:0]          bl_b;
	logic [WEIGHT_W-1:0]        bl_w;
	logic                       bl_done;
	logic [FLUX_W-1:0]          bl_result;
	logic [FA_W-1:0]            frow;
	int                         zsel;
	int                         fsel;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign flux_value = flux_q;
	assign status     = status_q;

	always_comb begin
		load_ok = (int'(zenith_index) < ZENITH_BINS) && (int'(azimuth_index) < AZIMUTH_BINS)
			&& (int'(energy_index) < ENERGY_POINTS) && (table_select <= SEL_NUEBAR);
		az_sat  = (int'(query_azimuth) >= AZIMUTH_BINS) ? 4'(AZIMUTH_BINS - 1) : query_azimuth;

		// Clamp the cosine into the grid and find its row pair.
		cz_ext = COS_W'(cz_q);
		czc_n  = cz_ext;
		if (cz_ext > COS_HI) begin
			czc_n = COS_HI;
		end
		if (cz_ext < COS_LO) begin
			czc_n = COS_LO;
		end
		zb_n = '0;
		for (int i = 0; i < ZENITH_BINS - 1; i++) begin
			if ((COS_GRID[i+1] < czc_n) && (czc_n <= COS_GRID[i])) begin
				zb_n = ZB_W'(i);
			end
		end
		if (czc_n <= COS_LO) begin
			zb_n = ZB_W'(ZENITH_BINS - 2);
		end

		zsel = (cmd_q == CMD_LOAD) ? int'(z_q) : int'(zb_q);
		fsel = (cmd_q == CMD_LOAD) ? int'(sel_q) - 1 : int'(flav_q);

		ec_lo = (en_q < gc0_q) ? gc0_q : en_q;
		ec_n  = (ec_lo > grid_rdata) ? grid_rdata : ec_lo;

		chk_ok = !eb1_q[ENERGY_W] && !eb2_q[ENERGY_W]
			&& !cb1_q[COS_W-1] && !cb2_q[COS_W-1];
		e_den  = eb1_q + eb2_q;
		c_den  = cb1_q + cb2_q;
	end

	// Memory ports.
	always_comb begin
		wr.grid_we   = (state_q == S_LDWR) && (sel_q == SEL_GRID);
		wr.flux_we   = (state_q == S_LDWR) && (sel_q != SEL_GRID);
		wr.grid_addr = cell_q + GA_W'(e_q);
		wr.flux_addr = fbase_q + FA_W'(cell_q) + FA_W'(e_q);
		wr.data      = val_q;

		case (state_q)
			S_GL:    grid_raddr = GA_W'(ENERGY_POINTS - 1);
			S_SRD:   grid_raddr = GA_W'(idx_q);
			S_C0:    grid_raddr = cell_q;
			S_C1:    grid_raddr = cell_q + GA_W'(ENERGY_POINTS - 1);
			S_C2:    grid_raddr = cell_q + GA_W'(eb_q);
			S_C3:    grid_raddr = cell_q + GA_W'(eb_q) + 1'b1;
			default: grid_raddr = '0;
		endcase

		frow = fbase_q + FA_W'(cell_q) + FA_W'(eb_q);
		case (state_q)
			S_F0:    flux_raddr = frow + 1'b1;
			S_F1:    flux_raddr = frow;
			S_F3:    flux_raddr = frow + ROWSTEP + 1'b1;
			S_F4:    flux_raddr = frow + ROWSTEP;
			default: flux_raddr = frow;
		endcase
	end

	// Shared unit operands.
	always_comb begin
		div_start = ((state_q == S_CHK) && chk_ok) || ((state_q == S_DIVE) && div_done);
		if (state_q == S_CHK) begin
			div_num = eb1_q[ENERGY_W-1:0];
			div_den = e_den[ENERGY_W-1:0];
		end else begin
			div_num = ENERGY_W'($unsigned(cb2_q));
			div_den = ENERGY_W'($unsigned(c_den));
		end

		bl_start = (state_q == S_F2) || (state_q == S_F5) || ((state_q == S_B1) && bl_done);
		bl_a     = (state_q == S_B1) ? r0_q : fa_q;
		bl_b     = (state_q == S_B1) ? bl_result : flux_rdata;
		bl_w     = (state_q == S_B1) ? w_c_q : w_e_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd_t'(command);
						z_q    <= zenith_index;
						e_q    <= energy_index;
						sel_q  <= table_select;
						val_q  <= table_value;
						en_q   <= query_energy;
						cz_q   <= query_cos_zenith;
						flav_q <= query_flavor;
						if (command == CMD_QUERY) begin
							az_q    <= az_sat;
							state_q <= S_G0;
						end else if (load_ok) begin
							az_q    <= azimuth_index;
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					row_q   <= ROW_W'(zsel * AZIMUTH_BINS + int'(az_q));
					fbase_q <= FA_W'(fsel * CELL_COUNT);
					cb1_q   <= COS_GRID[zb_q] - czc_q;
					cb2_q   <= czc_q - COS_GRID[ZB_W'(zb_q + 1'b1)];
					state_q <= S_CELL;
				end
				S_CELL: begin
					cell_q  <= GA_W'(int'(row_q) * ENERGY_POINTS);
					state_q <= (cmd_q == CMD_LOAD) ? S_LDWR : S_C0;
				end
				S_LDWR: begin
					state_q <= S_IDLE;
				end
				S_G0: begin
					state_q <= S_GL;
				end
				S_GL: begin
					g00_q   <= grid_rdata;
					state_q <= S_GCHK;
				end
				S_GCHK: begin
					if (en_q <= g00_q) begin
						eb_q    <= '0;
						state_q <= S_COS;
					end else if (en_q > grid_rdata) begin
						eb_q    <= EB_W'(ENERGY_POINTS - 2);
						state_q <= S_COS;
					end else begin
						eb_q    <= '0;
						idx_q   <= EB_W'(1);
						prev_q  <= g00_q;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					// Keep the highest interval that brackets the energy.
					if ((en_q > prev_q) && (en_q <= grid_rdata)) begin
						eb_q <= idx_q - 1'b1;
					end
					prev_q <= grid_rdata;
					if (int'(idx_q) == ENERGY_POINTS - 1) begin
						state_q <= S_COS;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_COS: begin
					czc_q   <= czc_n;
					zb_q    <= zb_n;
					state_q <= S_ROW;
				end
				S_C0: begin
					state_q <= S_C1;
				end
				S_C1: begin
					gc0_q   <= grid_rdata;
					state_q <= S_C2;
				end
				S_C2: begin
					ec_q    <= ec_n;
					state_q <= S_C3;
				end
				S_C3: begin
					eb1_q   <= {1'b0, ec_q} - {1'b0, grid_rdata};
					state_q <= S_C4;
				end
				S_C4: begin
					eb2_q   <= {1'b0, grid_rdata} - {1'b0, ec_q};
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (eb1_q[ENERGY_W] || eb2_q[ENERGY_W]) begin
						res_flux_q   <= '0;
						res_status_q <= ST_ERR_ENERGY;
						state_q      <= S_DONE;
					end else if (!chk_ok) begin
						res_flux_q   <= '0;
						res_status_q <= ST_ERR_COS;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_DIVE;
					end
				end
				S_DIVE: begin
					if (div_done) begin
						w_e_q   <= div_w;
						state_q <= S_DIVC;
					end
				end
				S_DIVC: begin
					if (div_done) begin
						w_c_q   <= div_w;
						state_q <= S_F0;
					end
				end
				S_F0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					fa_q    <= flux_rdata;
					state_q <= S_F2;
				end
				S_F2: begin
					state_q <= S_B0;
				end
				S_B0: begin
					if (bl_done) begin
						r0_q    <= bl_result;
						state_q <= S_F3;
					end
				end
				S_F3: begin
					state_q <= S_F4;
				end
				S_F4: begin
					fa_q    <= flux_rdata;
					state_q <= S_F5;
				end
				S_F5: begin
					state_q <= S_B1;
				end
				S_B1: begin
					if (bl_done) begin
						state_q <= S_B2;
					end
				end
				S_B2: begin
					if (bl_done) begin
						res_flux_q   <= bl_result;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || out_ready) begin
						flux_q      <= res_flux_q;
						status_q    <= res_status_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ftbi_store u_store (
		.clk        (clk),
		.wr         (wr),
		.grid_raddr (grid_raddr),
		.flux_raddr (flux_raddr),
		.grid_rdata (grid_rdata),
		.flux_rdata (flux_rdata)
	);

	ftbi_frac u_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.w      (div_w)
	);

	ftbi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bl_start),
		.a      (bl_a),
		.b      (bl_b),
		.w      (bl_w),
		.done   (bl_done),
		.result (bl_result)
	);

endmodule

// ----- hdl/ftbi_checker.sv -----
`timescale 1ns / 1ps
`include "flux_table_bilinear_interp_assert.svh"

module ftbi_checker import ftbi_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                command,
	input logic [4:0]          zenith_index,
	input logic [3:0]          azimuth_index,
	input logic [6:0]          energy_index,
	input logic [2:0]          table_select,
	input logic [63:0]         table_value,
	input logic [47:0]         query_energy,
	input logic signed [17:0]  query_cos_zenith,
	input logic [3:0]          query_azimuth,
	input logic [1:0]          query_flavor,
	input logic                out_valid,
	input logic                out_ready,
	input logic [63:0]         flux_value,
	input logic [1:0]          status
);

	// A stalled result beat holds.
	`FTBI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(flux_value) && $stable(status))

	// An error result carries zero flux.
	`FTBI_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != ST_OK, flux_value == 64'd0)

	// An accepted query keeps the block busy in the next cycle.
	`FTBI_ASSERT_NXT(a_query_busy, clk, arst_n, in_valid && in_ready && command == CMD_QUERY, !in_ready)

	// A result appears only at the end of a busy stretch.
	`FTBI_ASSERT_IMP(a_result_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind flux_table_bilinear_interp ftbi_checker u_ftbi_checker (.*);
